[hdl/prs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types and constants of the paged record store.
// ----------------------------------------------------------------------------
package prs_pkg;

   localparam int MaxPages     = 16;
   localparam int SlotsPerPage = 64;
   localparam int PageW        = $clog2(MaxPages);
   localparam int SlotW        = $clog2(SlotsPerPage);
   localparam int PageCntW     = $clog2(MaxPages + 1);
   localparam int SlotCntW     = $clog2(SlotsPerPage + 1);
   localparam int KeyAddrW     = PageW + SlotW;

   localparam logic [15:0] HeaderBytes  = 16'd16;
   localparam logic [16:0] SlotOverhead = 17'd4;

   // Request operation codes.
   localparam logic [1:0] OpInsert = 2'd0;
   localparam logic [1:0] OpSearch = 2'd1;
   localparam logic [1:0] OpStatus = 2'd2;

   // Result kinds.
   localparam logic [1:0] KindAck    = 2'd0;
   localparam logic [1:0] KindSearch = 2'd1;
   localparam logic [1:0] KindPages  = 2'd2;
   localparam logic [1:0] KindRecs   = 2'd3;

   // Byte address of the page size register.
   localparam logic [1:0] CsrPageSize = 2'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_INS_NEW,
      ST_INS_WRITE,
      ST_SRCH_ADDR,
      ST_SRCH_CMP,
      ST_STAT_PAGE,
      ST_OUT
   } state_type;

   // Controller commands to the datapath.
   typedef struct packed {
      logic capture;     // latch request fields
      logic page_clr;    // clear page counter
      logic page_inc;    // step page counter
      logic slot_clr;    // clear slot counter
      logic slot_inc;    // step slot counter
      logic key_rd;      // issue key memory read
      logic open_page;   // open a new page
      logic place;       // store record in current page
      logic set_ack;     // build insert ack from current page
      logic set_fail;    // build failed insert ack
      logic set_found;   // build search hit
      logic set_miss;    // build search miss
      logic set_pages;   // build page count result
      logic set_recs;    // build page record count result
   } cmd_type;

   // Datapath status to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       page_end;    // page counter reached pages in use
      logic       store_full;  // all pages open
      logic       page_fits;   // current page takes the record
      logic       slot_end;    // slot counter reached page record count
      logic       key_hit;     // registered key read matches
   } stat_type;

endpackage
`default_nettype wire

[hdl/prs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prs_datapath
// Page tables, key memory, scan counters and result register.
// ----------------------------------------------------------------------------
module prs_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire prs_pkg::cmd_type   cmd,
   output prs_pkg::stat_type       stat,
   input  wire logic [1:0]         req_op,
   input  wire logic [15:0]        req_record_size,
   input  wire logic signed [31:0] req_key,
   input  wire logic [15:0]        page_size,
   output logic [1:0]              rsp_kind,
   output logic signed [4:0]       rsp_page_index,
   output logic signed [6:0]       rsp_slot_index,
   output logic [6:0]              rsp_count,
   output logic                    rsp_error,
   output logic                    rsp_last
);
   import prs_pkg::*;

   logic [1:0]          op_ff;
   logic [16:0]         need_ff;
   logic [31:0]         key_ff;
   logic [PageCntW-1:0] pages_ff;
   logic [PageCntW-1:0] page_ff;
   logic [SlotCntW-1:0] slot_ff;
   logic [15:0]         free_ff [MaxPages];
   logic [SlotCntW-1:0] recs_ff [MaxPages];
   logic [31:0]         keys_mem [MaxPages * SlotsPerPage];
   logic [31:0]         rd_key_ff;
   logic [PageW-1:0]    pidx;
   logic [15:0]         fresh;
   logic [SlotCntW-1:0] cur_recs;
   logic [15:0]         cur_free;

   assign pidx     = page_ff[PageW-1:0];
   assign cur_recs = recs_ff[pidx];
   assign cur_free = free_ff[pidx];
   assign fresh    = (page_size >= HeaderBytes) ? page_size - HeaderBytes : 16'd0;

   // Status toward the controller.
   always_comb begin
      stat.op         = op_ff;
      stat.page_end   = (page_ff == pages_ff);
      stat.store_full = (pages_ff == PageCntW'(MaxPages));
      stat.page_fits  = ({1'b0, cur_free} >= need_ff) &&
                        (cur_recs < SlotCntW'(SlotsPerPage));
      stat.slot_end   = (slot_ff == cur_recs);
      stat.key_hit    = (rd_key_ff == key_ff);
   end

   // Request capture and scan counters.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         need_ff <= {1'b0, req_record_size} + SlotOverhead;
         key_ff  <= req_key;
      end
      if (cmd.page_clr) page_ff <= '0;
      else if (cmd.page_inc) page_ff <= page_ff + PageCntW'(1);
      if (cmd.slot_clr) slot_ff <= '0;
      else if (cmd.slot_inc) slot_ff <= slot_ff + SlotCntW'(1);
   end

   // Page count.
   always_ff @(posedge clock) begin
      if (reset) pages_ff <= '0;
      else if (cmd.open_page) pages_ff <= pages_ff + PageCntW'(1);
   end

   // Page tables: opening a page and placing a record.
   always_ff @(posedge clock) begin
      if (cmd.open_page) begin
         free_ff[pidx] <= fresh;
         recs_ff[pidx] <= '0;
      end else if (cmd.place) begin
         free_ff[pidx] <= cur_free - need_ff[15:0];
         recs_ff[pidx] <= cur_recs + SlotCntW'(1);
      end
   end

   // Key memory, one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.place) keys_mem[{pidx, cur_recs[SlotW-1:0]}] <= key_ff;
      if (cmd.key_rd) rd_key_ff <= keys_mem[{pidx, slot_ff[SlotW-1:0]}];
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.set_ack) begin
         rsp_kind <= KindAck; rsp_page_index <= 5'(pidx);
         rsp_slot_index <= 7'(cur_recs); rsp_count <= '0;
         rsp_error <= 1'b0; rsp_last <= 1'b1;
      end else if (cmd.set_fail) begin
         rsp_kind <= KindAck; rsp_page_index <= '1; rsp_slot_index <= '1;
         rsp_count <= '0; rsp_error <= 1'b1; rsp_last <= 1'b1;
      end else if (cmd.set_found) begin
         rsp_kind <= KindSearch; rsp_page_index <= 5'(pidx);
         rsp_slot_index <= 7'(slot_ff); rsp_count <= '0;
         rsp_error <= 1'b0; rsp_last <= 1'b1;
      end else if (cmd.set_miss) begin
         rsp_kind <= KindSearch; rsp_page_index <= '1; rsp_slot_index <= '1;
         rsp_count <= '0; rsp_error <= 1'b0; rsp_last <= 1'b1;
      end else if (cmd.set_pages) begin
         rsp_kind <= KindPages; rsp_page_index <= '1; rsp_slot_index <= '1;
         rsp_count <= 7'(pages_ff); rsp_error <= 1'b0;
         rsp_last <= (pages_ff == '0);
      end else if (cmd.set_recs) begin
         rsp_kind <= KindRecs; rsp_page_index <= 5'(pidx); rsp_slot_index <= '1;
         rsp_count <= 7'(cur_recs); rsp_error <= 1'b0;
         rsp_last <= (page_ff + PageCntW'(1) == pages_ff);
      end
   end

endmodule
`default_nettype wire

[hdl/prs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prs_ctrl
// Sequencer for insert scan, key search and status report.
// ----------------------------------------------------------------------------
module prs_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output prs_pkg::cmd_type      cmd,
   input  wire prs_pkg::stat_type stat
);
   import prs_pkg::*;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_INS_SCAN;
         ST_INS_SCAN: begin
            case (stat.op)
               OpInsert: begin
                  if (stat.page_end) state_in = ST_INS_NEW;
                  else if (stat.page_fits) state_in = ST_OUT;
               end
               OpSearch: state_in = ST_SRCH_ADDR;
               OpStatus: state_in = ST_OUT;
               default:  state_in = ST_IDLE;
            endcase
            ret_in = (stat.op == OpStatus) ? ST_STAT_PAGE : ST_IDLE;
         end
         ST_INS_NEW: state_in = stat.store_full ? ST_OUT : ST_INS_WRITE;
         ST_INS_WRITE: state_in = ST_OUT;
         ST_SRCH_ADDR: begin
            if (stat.page_end) state_in = ST_OUT;
            else if (!stat.slot_end) state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: state_in = stat.key_hit ? ST_OUT : ST_SRCH_ADDR;
         ST_STAT_PAGE: begin
            if (stat.page_end) begin
               state_in = ST_IDLE;
               ret_in   = ST_IDLE;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: if (!rsp_stall) state_in = ret_ff;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      case (state_ff)
         ST_IDLE: begin
            cmd.capture  = 1'b1;
            cmd.page_clr = 1'b1;
            cmd.slot_clr = 1'b1;
         end
         ST_INS_SCAN: begin
            case (stat.op)
               OpInsert: begin
                  if (!stat.page_end) begin
                     if (stat.page_fits) begin
                        cmd.set_ack = 1'b1;
                        cmd.place   = 1'b1;
                     end else begin
                        cmd.page_inc = 1'b1;
                     end
                  end
               end
               OpStatus: cmd.set_pages = 1'b1;
               default: begin
               end
            endcase
         end
         ST_INS_NEW: begin
            if (stat.store_full) cmd.set_fail = 1'b1;
            else cmd.open_page = 1'b1;
         end
         ST_INS_WRITE: begin
            if (stat.page_fits) begin
               cmd.set_ack = 1'b1;
               cmd.place   = 1'b1;
            end else cmd.set_fail = 1'b1;
         end
         ST_SRCH_ADDR: begin
            if (stat.page_end) cmd.set_miss = 1'b1;
            else if (stat.slot_end) begin
               cmd.page_inc = 1'b1;
               cmd.slot_clr = 1'b1;
            end else cmd.key_rd = 1'b1;
         end
         ST_SRCH_CMP: begin
            if (stat.key_hit) cmd.set_found = 1'b1;
            else cmd.slot_inc = 1'b1;
         end
         // The record count is latched from the current page while the page
         // counter moves on to the next one.
         ST_STAT_PAGE: begin
            if (!stat.page_end) begin
               cmd.set_recs = 1'b1;
               cmd.page_inc = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

[hdl/paged_record_store_first_fit_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paged_record_store_first_fit_unit
// Paged record store with first-fit insert, key search and status report.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake
//  req_     in         req_valid / req_stall
//  rsp_     out        rsp_valid / rsp_stall
//  csr_     in         APB, psel/penable/pwrite, pready tied high
//
// One transaction at a time. Insert scans the pages in use from the first
// and opens a new page if none fits; search walks the key memory slot by
// slot, up to 1024 slots. Status gives the page count result, then one
// result for each page in use.
// Reset is synchronous; page tables and keys are written before use.
// A stalled result holds; no new request is taken until the last is taken.
module paged_record_store_first_fit_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_op,
   input  wire logic [15:0]        req_record_size,
   input  wire logic signed [31:0] req_key,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_kind,
   output logic signed [4:0]       rsp_page_index,
   output logic signed [6:0]       rsp_slot_index,
   output logic [6:0]              rsp_count,
   output logic                    rsp_error,
   output logic                    rsp_last,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [1:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import prs_pkg::*;

   cmd_type     cmd;
   stat_type    stat;
   logic [15:0] page_size_ff;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CsrPageSize) ? {16'd0, page_size_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) page_size_ff <= 16'd256;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CsrPageSize)
         page_size_ff <= csr_pwdata[15:0];
   end

   prs_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .stat
   );

   prs_datapath u_dp (
      .clock, .reset, .cmd, .stat, .req_op, .req_record_size, .req_key,
      .page_size (page_size_ff),
      .rsp_kind, .rsp_page_index, .rsp_slot_index, .rsp_count,
      .rsp_error, .rsp_last
   );

endmodule
`default_nettype wire
